// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl file of the command parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fcp_pkg.sv =====
// shared types and constants of the framed command parser
`timescale 1ns / 1ps
`default_nettype none

package fcp_pkg;

  // body store depth default
  localparam int DEFAULT_BODY_DEPTH = 8;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int TYPE_W    = 3;
  localparam int PAYLOAD_W = 5;

  // number of leading body bytes the decoder looks at
  localparam int HEAD_LEN = 5;

  // framing characters
  localparam logic [BYTE_W-1:0] CH_START = 8'h24;  // '$'
  localparam logic [BYTE_W-1:0] CH_END   = 8'h23;  // '#'

  // command letters and digits
  localparam logic [BYTE_W-1:0] CH_G = 8'h47;
  localparam logic [BYTE_W-1:0] CH_O = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_E = 8'h45;
  localparam logic [BYTE_W-1:0] CH_N = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_D = 8'h44;
  localparam logic [BYTE_W-1:0] CH_C = 8'h43;
  localparam logic [BYTE_W-1:0] CH_I = 8'h49;
  localparam logic [BYTE_W-1:0] CH_S = 8'h53;
  localparam logic [BYTE_W-1:0] CH_L = 8'h4C;
  localparam logic [BYTE_W-1:0] CH_M = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CH_1 = 8'h31;
  localparam logic [BYTE_W-1:0] CH_2 = 8'h32;
  localparam logic [BYTE_W-1:0] CH_4 = 8'h34;
  localparam logic [BYTE_W-1:0] CH_6 = 8'h36;
  localparam logic [BYTE_W-1:0] CH_8 = 8'h38;

  // command kinds
  typedef enum logic [TYPE_W-1:0] {
    CMD_GO  = 3'd0,
    CMD_END = 3'd1,
    CMD_CON = 3'd2,
    CMD_DIS = 3'd3,
    CMD_LIM = 3'd4
  } cmd_kind_t;

  // largest payload value
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX = 5'd24;

  // decoder verdict on a held body
  typedef struct packed {
    logic                 hit;
    cmd_kind_t            kind;
    logic [PAYLOAD_W-1:0] payload;
  } dec_res_t;

endpackage

`default_nettype wire

// ===== sv/fcp_decode.sv =====
// command decoder: fixed-position compares over the first body bytes
`timescale 1ns / 1ps
`default_nettype none

module fcp_decode #(
  parameter int CNT_W = 4
) (
  input  wire logic [fcp_pkg::BYTE_W-1:0] head [fcp_pkg::HEAD_LEN],
  input  wire logic [CNT_W-1:0]           count,
  output fcp_pkg::dec_res_t               res
);

  logic is_go, is_end, is_con, is_dis, port_ok;
  logic lim_pre, lim_00, lim_08, lim_16, lim_24;

  // per-command matches, gated by body length
  always_comb begin
    port_ok = (head[3] == fcp_pkg::CH_0) || (head[3] == fcp_pkg::CH_1) ||
              (head[3] == fcp_pkg::CH_2);
    is_go   = (count == CNT_W'(2)) && (head[0] == fcp_pkg::CH_G) &&
              (head[1] == fcp_pkg::CH_O);
    is_end  = (count == CNT_W'(3)) && (head[0] == fcp_pkg::CH_E) &&
              (head[1] == fcp_pkg::CH_N) && (head[2] == fcp_pkg::CH_D);
    is_con  = (count == CNT_W'(4)) && port_ok && (head[0] == fcp_pkg::CH_C) &&
              (head[1] == fcp_pkg::CH_O) && (head[2] == fcp_pkg::CH_N);
    is_dis  = (count == CNT_W'(4)) && port_ok && (head[0] == fcp_pkg::CH_D) &&
              (head[1] == fcp_pkg::CH_I) && (head[2] == fcp_pkg::CH_S);
    lim_pre = (count == CNT_W'(5)) && (head[0] == fcp_pkg::CH_L) &&
              (head[1] == fcp_pkg::CH_I) && (head[2] == fcp_pkg::CH_M);
    lim_00  = (head[3] == fcp_pkg::CH_0) && (head[4] == fcp_pkg::CH_0);
    lim_08  = (head[3] == fcp_pkg::CH_0) && (head[4] == fcp_pkg::CH_8);
    lim_16  = (head[3] == fcp_pkg::CH_1) && (head[4] == fcp_pkg::CH_6);
    lim_24  = (head[3] == fcp_pkg::CH_2) && (head[4] == fcp_pkg::CH_4);
  end

  // verdict and payload
  always_comb begin
    res.hit     = 1'b0;
    res.kind    = fcp_pkg::CMD_GO;
    res.payload = '0;
    if (is_go) begin
      res.hit  = 1'b1;
      res.kind = fcp_pkg::CMD_GO;
    end else if (is_end) begin
      res.hit  = 1'b1;
      res.kind = fcp_pkg::CMD_END;
    end else if (is_con || is_dis) begin
      // port digits '0'..'2' carry the port number in their low bits
      res.hit     = 1'b1;
      res.kind    = is_con ? fcp_pkg::CMD_CON : fcp_pkg::CMD_DIS;
      res.payload = fcp_pkg::PAYLOAD_W'(head[3][1:0]);
    end else if (lim_pre && (lim_00 || lim_08 || lim_16 || lim_24)) begin
      res.hit     = 1'b1;
      res.kind    = fcp_pkg::CMD_LIM;
      res.payload = lim_08 ? 5'd8 : (lim_16 ? 5'd16 : (lim_24 ? 5'd24 : 5'd0));
    end
  end

endmodule

`default_nettype wire

// ===== sv/framed_command_parser_unit.sv =====
// framed command parser: byte framing, body store and registered result
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  in      | in_valid, in_stall, in_rx_byte      | to block
//  out     | out_valid, out_stall, out_cmd_kind, | from block
//          | out_cmd_payload                     |
//
// one word is taken per cycle while in_stall is low; a result shows on out in the cycle after its '#' is taken
// frame state, body count and body store update at the edge a word is taken
// reset clears frame state, body count and the result valid flag
// in_stall is high only while a held result is stalled by out_stall
`timescale 1ns / 1ps
`default_nettype none

module framed_command_parser_unit #(
  parameter int BODY_DEPTH = fcp_pkg::DEFAULT_BODY_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [fcp_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [fcp_pkg::TYPE_W-1:0]         out_cmd_kind,
  output logic [fcp_pkg::PAYLOAD_W-1:0]      out_cmd_payload
);

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(BODY_DEPTH + 1);
  localparam int IDX_W = $clog2(BODY_DEPTH);

  logic                             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]                 body_count_r, body_count_nxt;
  logic [fcp_pkg::BYTE_W-1:0]       body_r [BODY_DEPTH];
  logic [fcp_pkg::BYTE_W-1:0]       head [fcp_pkg::HEAD_LEN];
  logic                             out_valid_r, out_valid_nxt;
  logic [fcp_pkg::TYPE_W-1:0]       out_type_r;
  logic [fcp_pkg::PAYLOAD_W-1:0]    out_payload_r;
  logic                             accept, body_wr, emit;
  fcp_pkg::dec_res_t                dec;

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // leading body bytes for the decoder
  always_comb begin
    for (int i = 0; i < fcp_pkg::HEAD_LEN; i++) begin
      head[i] = body_r[i];
    end
  end

  fcp_decode #(
    .CNT_W (CNT_W)
  ) u_decode (
    .head  (head),
    .count (body_count_r),
    .res   (dec)
  );

  // framing next state
  always_comb begin
    in_frame_nxt   = in_frame_r;
    body_count_nxt = body_count_r;
    body_wr        = 1'b0;
    emit           = 1'b0;
    if (accept) begin
      if (!in_frame_r) begin
        if (in_rx_byte == fcp_pkg::CH_START) begin
          in_frame_nxt   = 1'b1;
          body_count_nxt = '0;
        end
      end else if (in_rx_byte == fcp_pkg::CH_END) begin
        in_frame_nxt = 1'b0;
        emit         = dec.hit;
      end else if (in_rx_byte == fcp_pkg::CH_START) begin
        body_count_nxt = '0;
      end else if (body_count_r < CNT_W'(BODY_DEPTH)) begin
        body_wr        = 1'b1;
        body_count_nxt = body_count_r + CNT_W'(1);
      end else begin
        // overflow aborts the frame
        in_frame_nxt = 1'b0;
      end
    end
  end

  // result valid next state
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      body_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      body_count_r <= body_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // body store, written at the current count
  always_ff @(posedge clk) begin
    if (body_wr) begin
      body_r[body_count_r[IDX_W-1:0]] <= in_rx_byte;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_type_r    <= dec.kind;
      out_payload_r <= dec.payload;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cmd_kind    = out_type_r;
  assign out_cmd_payload = out_payload_r;

  // checks
  `FCP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, body_count_r <= CNT_W'(BODY_DEPTH), "body count past depth")
  `FCP_ASSERT_IMP(a_emit_len, clk, rst_n, emit, (body_count_r >= CNT_W'(2)) && (body_count_r <= CNT_W'(5)), "result from body of bad length")
  `FCP_ASSERT_NXT(a_hunt_quiet, clk, rst_n, accept && !in_frame_r && !out_valid_r, !out_valid_r, "result while hunting")
  `FCP_ASSERT_IMP(a_out_range, clk, rst_n, out_valid_r, (out_type_r <= fcp_pkg::CMD_LIM) && (out_payload_r <= fcp_pkg::PAYLOAD_MAX), "result word out of range")

endmodule

`default_nettype wire

// ===== verif/framed_command_parser_checker.sv =====
// command word checker: follows both channels, predicts commands and compares them
`timescale 1ns / 1ps

module framed_command_parser_checker
  import fcp_pkg::*;
#(
  parameter int BODY_DEPTH = DEFAULT_BODY_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [TYPE_W-1:0]    out_cmd_kind,
  input  logic [PAYLOAD_W-1:0] out_cmd_payload,
  output int                   fail_count,
  output int                   pending_count
);

  typedef struct packed {
    cmd_kind_t            kind;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_word_t;

  // predicted parser state
  logic              frame_open;
  logic [BYTE_W-1:0] body_bytes [BODY_DEPTH];
  int                held_len;

  // commands still owed by the block, oldest first
  cmd_word_t cmd_queue [$];
  int        miss_count;

  // match the held body against the command set
  function automatic bit decode_body(output cmd_word_t cmd);
    cmd.kind    = CMD_GO;
    cmd.payload = '0;
    if (held_len == 2 && body_bytes[0] == CH_G && body_bytes[1] == CH_O) begin
      return 1'b1;
    end
    if (held_len == 3 && body_bytes[0] == CH_E && body_bytes[1] == CH_N &&
        body_bytes[2] == CH_D) begin
      cmd.kind = CMD_END;
      return 1'b1;
    end
    if (held_len == 4 &&
        (body_bytes[3] == CH_0 || body_bytes[3] == CH_1 || body_bytes[3] == CH_2)) begin
      cmd.payload = PAYLOAD_W'(body_bytes[3] - CH_0);
      if (body_bytes[0] == CH_C && body_bytes[1] == CH_O && body_bytes[2] == CH_N) begin
        cmd.kind = CMD_CON;
        return 1'b1;
      end
      if (body_bytes[0] == CH_D && body_bytes[1] == CH_I && body_bytes[2] == CH_S) begin
        cmd.kind = CMD_DIS;
        return 1'b1;
      end
    end
    if (held_len == 5 && body_bytes[0] == CH_L && body_bytes[1] == CH_I &&
        body_bytes[2] == CH_M) begin
      cmd.kind = CMD_LIM;
      if ({body_bytes[3], body_bytes[4]} == {CH_0, CH_0}) begin
        cmd.payload = 5'd0;
        return 1'b1;
      end
      if ({body_bytes[3], body_bytes[4]} == {CH_0, CH_8}) begin
        cmd.payload = 5'd8;
        return 1'b1;
      end
      if ({body_bytes[3], body_bytes[4]} == {CH_1, CH_6}) begin
        cmd.payload = 5'd16;
        return 1'b1;
      end
      if ({body_bytes[3], body_bytes[4]} == {CH_2, CH_4}) begin
        cmd.payload = 5'd24;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // advance the predicted framing by one received word
  task automatic take_rx_byte(input logic [BYTE_W-1:0] c);
    cmd_word_t cmd;
    if (!frame_open) begin
      if (c == CH_START) begin
        frame_open = 1'b1;
        held_len   = 0;
      end
    end else if (c == CH_END) begin
      frame_open = 1'b0;
      if (decode_body(cmd)) cmd_queue.push_back(cmd);
    end else if (c == CH_START) begin
      held_len = 0;
    end else if (held_len < BODY_DEPTH) begin
      body_bytes[held_len] = c;
      held_len++;
    end else begin
      // overflow aborts the frame and drops the word
      frame_open = 1'b0;
    end
  endtask

  // compare results first, then predict from the input word taken at this edge
  always @(posedge clk) begin : watch
    cmd_word_t want;
    if (!rst_n) begin
      frame_open = 1'b0;
      held_len   = 0;
      miss_count = 0;
      cmd_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cmd_queue.size() == 0) begin
          $display("%0t: unexpected command word: expected none, actual kind %0d payload %0d",
                   $time, out_cmd_kind, out_cmd_payload);
          miss_count++;
        end else begin
          want = cmd_queue.pop_front();
          if (out_cmd_kind !== want.kind) begin
            $display("%0t: cmd_kind mismatch: expected %0d, actual %0d",
                     $time, want.kind, out_cmd_kind);
            miss_count++;
          end
          if (out_cmd_payload !== want.payload) begin
            $display("%0t: cmd_payload mismatch: expected %0d, actual %0d",
                     $time, want.payload, out_cmd_payload);
            miss_count++;
          end
        end
      end
      if (in_valid && !in_stall) take_rx_byte(in_rx_byte);
    end
    fail_count    <= miss_count;
    pending_count <= cmd_queue.size();
  end

endmodule

// ===== verif/framed_command_parser_unit_tb.sv =====
// testbench top: drives framed byte streams into the command parser and gives the verdict
`timescale 1ns / 1ps

module framed_command_parser_unit_tb;
  import fcp_pkg::*;

  localparam int BODY_DEPTH = DEFAULT_BODY_DEPTH;
  localparam int RX_WORDS   = 1300;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_stall  = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [TYPE_W-1:0]    out_cmd_kind;
  logic [PAYLOAD_W-1:0] out_cmd_payload;

  int fail_count;
  int pending_count;
  int sent_words = 0;

  // idle pattern state of each side
  int tx_run_left = 0;
  bit tx_no_idle  = 1'b0;
  int rx_run_left = 0;
  bit rx_no_idle  = 1'b0;

  // bytes of the frame being built
  logic [BYTE_W-1:0] frame_bytes [$];

  framed_command_parser_unit #(
    .BODY_DEPTH(BODY_DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cmd_kind   (out_cmd_kind),
    .out_cmd_payload(out_cmd_payload)
  );

  framed_command_parser_checker #(
    .BODY_DEPTH(BODY_DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cmd_kind   (out_cmd_kind),
    .out_cmd_payload(out_cmd_payload),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  always #1 clk = ~clk;

  // wait before the next word: runs of random gaps, some runs with none
  function automatic int draw_wait(inout int run_left, inout bit no_idle);
    if (run_left == 0) begin
      run_left = $urandom_range(4, 40);
      no_idle  = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // any byte but the framing characters
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255));
    while (b == CH_START || b == CH_END);
    return b;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  // append a well-formed command body with random content
  function automatic void add_command();
    cmd_kind_t kind;
    kind = cmd_kind_t'($urandom_range(0, 4));
    case (kind)
      CMD_GO:  add_text("GO");
      CMD_END: add_text("END");
      CMD_CON: add_text($sformatf("CON%0d", $urandom_range(0, 2)));
      CMD_DIS: add_text($sformatf("DIS%0d", $urandom_range(0, 2)));
      default: add_text($sformatf("LIM%02d", 8 * $urandom_range(0, 3)));
    endcase
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(input logic [BYTE_W-1:0] b);
    int gap;
    gap = draw_wait(tx_run_left, tx_no_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk);
    while (in_stall);
    sent_words++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  // build one random frame, mostly well formed, and send it
  task automatic send_random_frame();
    int pick;
    int body_at;
    int spot;
    int target;
    frame_bytes.delete();
    // noise while hunting, '#' among it
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3))
        frame_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_END : plain_byte());
    end
    pick = $urandom_range(0, 99);
    if (pick < 95) frame_bytes.push_back(CH_START);
    if (pick < 58 && $urandom_range(0, 7) == 0) begin
      // restart inside the frame
      repeat ($urandom_range(0, BODY_DEPTH)) frame_bytes.push_back(plain_byte());
      frame_bytes.push_back(CH_START);
    end
    body_at = frame_bytes.size();
    if (pick < 58) begin
      add_command();
      frame_bytes.push_back(CH_END);
    end else if (pick < 72) begin
      // one body byte spoiled, often a near-miss digit
      add_command();
      spot = $urandom_range(body_at, frame_bytes.size() - 1);
      if ($urandom_range(0, 1) == 0) frame_bytes[spot] = BYTE_W'($urandom_range(0, 255));
      else frame_bytes[spot] = BYTE_W'(CH_0 + $urandom_range(0, 9));
      frame_bytes.push_back(CH_END);
    end else if (pick < 80) begin
      // body one byte short or long
      add_command();
      if ($urandom_range(0, 1) == 0) void'(frame_bytes.pop_back());
      else frame_bytes.push_back(plain_byte());
      frame_bytes.push_back(CH_END);
    end else if (pick < 86) begin
      // body overflow, the '#' after it lands while hunting
      if ($urandom_range(0, 1) == 0) add_command();
      target = BODY_DEPTH + $urandom_range(1, 2);
      while (frame_bytes.size() - body_at < target) frame_bytes.push_back(plain_byte());
      if ($urandom_range(0, 1) == 0) frame_bytes.push_back(CH_END);
    end else if (pick < 90) begin
      // full body, no overflow
      while (frame_bytes.size() - body_at < BODY_DEPTH) frame_bytes.push_back(plain_byte());
      frame_bytes.push_back(CH_END);
    end else if (pick < 95) begin
      // empty frame
      frame_bytes.push_back(CH_END);
    end else begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    end
    foreach (frame_bytes[i]) send_word(frame_bytes[i]);
  endtask

  // stimulus and verdict
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ignored while hunting, '#' too
    send_word(8'h00);
    send_word(8'hFF);
    send_word(CH_END);
    // empty frame, restart then GO, and every other command
    send_text("$#");
    send_text("$$GO#");
    send_text("$END#");
    send_text("$CON0#");
    send_text("$DIS2#");
    send_text("$LIM24#");

    while (sent_words < RX_WORDS) send_random_frame();
    in_valid <= 1'b0;

    do @(posedge clk);
    while (pending_count != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("framed_command_parser_unit verification clean");
    end else begin
      $display("framed_command_parser_unit verification failed");
    end
    $finish;
  end

  // result sink: random stalls, two long hold-offs to back up the input
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    forever begin
      if (taken == 25 || taken == 80) hold = 300;
      else hold = draw_wait(rx_run_left, rx_no_idle);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk);
      while (!out_valid);
      taken++;
    end
  end

  // watchdog
  initial begin
    #1000000;
    $display("framed_command_parser_unit verification failed");
    $finish;
  end

endmodule
